// ===== src/multitone_dsb_signal_synth_defines.svh =====
// Assertion macros shared by the multitone DSB sample synthesizer.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MULTITONE_DSB_SIGNAL_SYNTH_DEFINES_SVH
`define MULTITONE_DSB_SIGNAL_SYNTH_DEFINES_SVH

`define MTDSB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MTDSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mtdsb_pkg.sv =====
// Package for the multitone DSB sample synthesizer: field widths, register
// codes, pipeline stage numbers and the sine table generator. No dependencies.
package mtdsb_pkg;

    localparam int MAX_TONES = 2;
    localparam int TONE_SEL_W = $clog2(MAX_TONES);
    localparam int CFG_INDEX_W = TONE_SEL_W + 2;
    localparam int CFG_DATA_W = 32;
    localparam int AMP_W = 16;
    localparam int PHASE_W = 32;
    localparam int ROM_W = 15;
    localparam int TRIG_W = 16;
    localparam int AC_W = 32;
    localparam int PROD_W = 48;
    localparam int TERM_W = 16;
    localparam int SAMPLE_W = 17;
    localparam int ROUND_SHIFT = 30;

    localparam int STG_MUL = 0;
    localparam int STG_ADDR = 1;
    localparam int STG_ROM = 2;
    localparam int STG_AMP = 3;
    localparam int STG_PROD = 4;
    localparam int STG_ROUND = 5;
    localparam int STG_OUT = 6;
    localparam int NUM_STAGES = 7;

    typedef enum logic [1:0] {
        FLD_AMP   = 2'd0,
        FLD_CSTEP = 2'd1,
        FLD_MSTEP = 2'd2,
        FLD_PHASE = 2'd3
    } cfg_field_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Quarter-wave sine entry k of a table with 2^qbits steps, in unsigned Q0.15.
    function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] mag;
        logic signed [63:0] acc;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(k)) >> qbits;
        mag = x;
        acc = $signed(x);
        for (int n = 0; n < 6; n++)
        begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = mag / TAYLOR_DIV[n];
            if ((n % 2) == 0)
                acc = acc - $signed(mag);
            else
                acc = acc + $signed(mag);
        end
        if (acc < 0)
            acc = '0;
        v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[ROM_W-1:0];
    endfunction

endpackage

// ===== src/multitone_dsb_signal_synth.sv =====
// Multitone double-sideband sample synthesizer: one summed sample per time-step
// item. Takes one item every clock while the output does not stall; its seven
// stages keep the phase, amplitude and product multipliers apart, and a stalled
// output fills bubbles before it holds off new items. Each tone contributes
// amplitude * cos(mod phase) * sin(carrier phase) from a quarter-wave table.
// The user must make configuration writes only while idle; the block does not
// enforce it. Depends on mtdsb_pkg and multitone_dsb_signal_synth_defines.svh.
`include "multitone_dsb_signal_synth_defines.svh"

module multitone_dsb_signal_synth #(
    parameter int NUM_TONES = 2,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mtdsb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mtdsb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mtdsb_pkg::PHASE_W-1:0]        time_step,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mtdsb_pkg::SAMPLE_W-1:0] sample
);

    localparam int IDX_W = SINE_TABLE_BITS;
    localparam int F_W = SINE_TABLE_BITS - 2;
    localparam int ADDR_W = SINE_TABLE_BITS - 1;
    localparam int QTR_LEN = 1 << F_W;
    localparam int LAST = mtdsb_pkg::NUM_STAGES - 1;

    logic signed [mtdsb_pkg::AMP_W-1:0]   amp_reg   [mtdsb_pkg::MAX_TONES];
    logic        [mtdsb_pkg::PHASE_W-1:0] cstep_reg [mtdsb_pkg::MAX_TONES];
    logic        [mtdsb_pkg::PHASE_W-1:0] mstep_reg [mtdsb_pkg::MAX_TONES];
    logic        [mtdsb_pkg::PHASE_W-1:0] phase_reg [mtdsb_pkg::MAX_TONES];

    logic [mtdsb_pkg::NUM_STAGES-1:0] valid_reg;
    logic [mtdsb_pkg::NUM_STAGES-1:0] valid_next;
    logic [mtdsb_pkg::NUM_STAGES-1:0] stage_en;

    logic [mtdsb_pkg::ROM_W-1:0] sine_rom [QTR_LEN+1];

    logic        [mtdsb_pkg::PHASE_W-1:0] cmul_reg   [NUM_TONES];
    logic        [mtdsb_pkg::PHASE_W-1:0] mmul_reg   [NUM_TONES];
    logic        [ADDR_W-1:0]             caddr_reg  [NUM_TONES];
    logic        [ADDR_W-1:0]             maddr_reg  [NUM_TONES];
    logic                                 cneg_a_reg [NUM_TONES];
    logic                                 mneg_a_reg [NUM_TONES];
    logic        [mtdsb_pkg::ROM_W-1:0]   cmag_reg   [NUM_TONES];
    logic        [mtdsb_pkg::ROM_W-1:0]   mmag_reg   [NUM_TONES];
    logic                                 cneg_r_reg [NUM_TONES];
    logic                                 mneg_r_reg [NUM_TONES];
    logic signed [mtdsb_pkg::AC_W-1:0]    ac_reg     [NUM_TONES];
    logic signed [mtdsb_pkg::TRIG_W-1:0]  sin_reg    [NUM_TONES];
    logic signed [mtdsb_pkg::PROD_W-1:0]  prod_reg   [NUM_TONES];
    logic signed [mtdsb_pkg::TERM_W-1:0]  term_reg   [NUM_TONES];
    logic signed [mtdsb_pkg::SAMPLE_W-1:0] sample_reg;

    logic        [mtdsb_pkg::PHASE_W-1:0] cphase     [NUM_TONES];
    logic        [mtdsb_pkg::PHASE_W-1:0] mphase     [NUM_TONES];
    logic        [IDX_W-1:0]              cidx       [NUM_TONES];
    logic        [IDX_W-1:0]              midx       [NUM_TONES];
    logic        [ADDR_W-1:0]             caddr      [NUM_TONES];
    logic        [ADDR_W-1:0]             maddr      [NUM_TONES];
    logic signed [mtdsb_pkg::TRIG_W-1:0]  sin_val    [NUM_TONES];
    logic signed [mtdsb_pkg::TRIG_W-1:0]  cos_val    [NUM_TONES];
    logic signed [mtdsb_pkg::PROD_W-1:0]  prod_rnd   [NUM_TONES];
    logic signed [mtdsb_pkg::SAMPLE_W-1:0] sample_next;

    logic [mtdsb_pkg::TONE_SEL_W-1:0] cfg_tone;
    mtdsb_pkg::cfg_field_t            cfg_field;

    assign cfg_ready = 1'b1;
    assign cfg_tone = cfg_index[mtdsb_pkg::CFG_INDEX_W-1 -: mtdsb_pkg::TONE_SEL_W];
    assign cfg_field = mtdsb_pkg::cfg_field_t'(cfg_index[1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < mtdsb_pkg::MAX_TONES; n++)
            begin
                amp_reg[n] <= '0;
                cstep_reg[n] <= '0;
                mstep_reg[n] <= '0;
                phase_reg[n] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_field)
                mtdsb_pkg::FLD_AMP:   amp_reg[cfg_tone] <= $signed(cfg_data[mtdsb_pkg::AMP_W-1:0]);
                mtdsb_pkg::FLD_CSTEP: cstep_reg[cfg_tone] <= cfg_data;
                mtdsb_pkg::FLD_MSTEP: mstep_reg[cfg_tone] <= cfg_data;
                mtdsb_pkg::FLD_PHASE: phase_reg[cfg_tone] <= cfg_data;
                default:              amp_reg[cfg_tone] <= amp_reg[cfg_tone];
            endcase
        end
    end

    for (genvar k = 0; k <= QTR_LEN; k++)
    begin : g_rom
        assign sine_rom[k] = mtdsb_pkg::sine_entry(k, F_W);
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < mtdsb_pkg::NUM_STAGES; k++)
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_comb
    begin
        for (int n = 0; n < NUM_TONES; n++)
        begin
            cphase[n] = phase_reg[n] + cmul_reg[n];
            mphase[n] = phase_reg[n] + mmul_reg[n];
            cidx[n] = cphase[n][mtdsb_pkg::PHASE_W-1 -: IDX_W];
            midx[n] = mphase[n][mtdsb_pkg::PHASE_W-1 -: IDX_W] + IDX_W'(QTR_LEN);
            caddr[n] = cidx[n][F_W] ? ADDR_W'(QTR_LEN) - ADDR_W'(cidx[n][F_W-1:0])
                                    : ADDR_W'(cidx[n][F_W-1:0]);
            maddr[n] = midx[n][F_W] ? ADDR_W'(QTR_LEN) - ADDR_W'(midx[n][F_W-1:0])
                                    : ADDR_W'(midx[n][F_W-1:0]);
            sin_val[n] = cneg_r_reg[n] ? -$signed({1'b0, cmag_reg[n]})
                                       : $signed({1'b0, cmag_reg[n]});
            cos_val[n] = mneg_r_reg[n] ? -$signed({1'b0, mmag_reg[n]})
                                       : $signed({1'b0, mmag_reg[n]});
            prod_rnd[n] = prod_reg[n] + mtdsb_pkg::PROD_W'(64'sd1 <<< (mtdsb_pkg::ROUND_SHIFT - 1));
        end
        sample_next = '0;
        for (int n = 0; n < NUM_TONES; n++)
            sample_next = sample_next + mtdsb_pkg::SAMPLE_W'(term_reg[n]);
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < NUM_TONES; n++)
        begin
            if (stage_en[mtdsb_pkg::STG_MUL])
            begin
                cmul_reg[n] <= time_step * cstep_reg[n];
                mmul_reg[n] <= time_step * mstep_reg[n];
            end
            if (stage_en[mtdsb_pkg::STG_ADDR])
            begin
                caddr_reg[n] <= caddr[n];
                maddr_reg[n] <= maddr[n];
                cneg_a_reg[n] <= cidx[n][IDX_W-1];
                mneg_a_reg[n] <= midx[n][IDX_W-1];
            end
            if (stage_en[mtdsb_pkg::STG_ROM])
            begin
                cmag_reg[n] <= sine_rom[caddr_reg[n]];
                mmag_reg[n] <= sine_rom[maddr_reg[n]];
                cneg_r_reg[n] <= cneg_a_reg[n];
                mneg_r_reg[n] <= mneg_a_reg[n];
            end
            if (stage_en[mtdsb_pkg::STG_AMP])
            begin
                ac_reg[n] <= mtdsb_pkg::AC_W'(amp_reg[n]) * mtdsb_pkg::AC_W'(cos_val[n]);
                sin_reg[n] <= sin_val[n];
            end
            if (stage_en[mtdsb_pkg::STG_PROD])
                prod_reg[n] <= mtdsb_pkg::PROD_W'(ac_reg[n]) * mtdsb_pkg::PROD_W'(sin_reg[n]);
            if (stage_en[mtdsb_pkg::STG_ROUND])
                term_reg[n] <= prod_rnd[n][mtdsb_pkg::ROUND_SHIFT +: mtdsb_pkg::TERM_W];
        end
        if (stage_en[mtdsb_pkg::STG_OUT])
            sample_reg <= sample_next;
    end

    assign in_ready = stage_en[0];
    assign out_valid = valid_reg[LAST];
    assign sample = sample_reg;

    `MTDSB_ASSERT_IMPLIES(a_full_when_blocked, !in_ready, &valid_reg, "input blocked with a bubble in the pipeline")
    `MTDSB_ASSERT_NEXT(a_stalled_stage_holds, (valid_reg & ~stage_en) != '0, (valid_reg & $past(valid_reg & ~stage_en)) == $past(valid_reg & ~stage_en), "stalled item was dropped")
    `MTDSB_ASSERT_IMPLIES(a_item_count, $past(rst_n), $countones(valid_reg) == $past($countones(valid_reg)) + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)), "pipeline item count mismatch")
    `MTDSB_ASSERT_IMPLIES(a_term_range, valid_reg[mtdsb_pkg::STG_ROUND], term_reg[0] != 16'sh8000, "tone term out of range")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for multitone_dsb_signal_synth: random and directed time steps
// across several tone settings, each sample checked against an in-bench predictor.
// Depends on mtdsb_pkg and the synthesizer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_TONES = 2;
    localparam int TB_TABLE_BITS = 10;
    localparam int QTR_LEN = 1 << (TB_TABLE_BITS - 2);
    localparam logic [63:0] QUARTER_TURN_RAD_Q30 = 64'd1686629713;
    localparam int PIPE_LATENCY = mtdsb_pkg::NUM_STAGES;
    localparam int LONG_HOLD = 60;
    localparam int ITEMS_PER_PHASE = 120;

    typedef struct {
        logic [31:0] amp_word;
        logic [31:0] cstep;
        logic [31:0] mstep;
        logic [31:0] phase;
    } tone_cfg_t;
    typedef tone_cfg_t tone_set_t [mtdsb_pkg::MAX_TONES];

    typedef struct {
        logic [31:0] t;
        logic signed [mtdsb_pkg::SAMPLE_W-1:0] level;
    } expected_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mtdsb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mtdsb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [mtdsb_pkg::PHASE_W-1:0] time_step = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [mtdsb_pkg::SAMPLE_W-1:0] sample;

    logic in_acc = 1'b0;
    logic recv_hold = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int steps_sent = 0;
    int samples_checked = 0;
    int settings_applied = 0;

    logic [31:0] steps_q[$];
    expected_sample_t pending_samples[$];
    event start_hold;

    int sine_rom [QTR_LEN + 1];
    logic signed [mtdsb_pkg::AMP_W-1:0] amp_m [mtdsb_pkg::MAX_TONES];
    logic [31:0] cstep_m [mtdsb_pkg::MAX_TONES];
    logic [31:0] mstep_m [mtdsb_pkg::MAX_TONES];
    logic [31:0] phase_m [mtdsb_pkg::MAX_TONES];

    multitone_dsb_signal_synth #(
        .NUM_TONES(TB_TONES),
        .SINE_TABLE_BITS(TB_TABLE_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .time_step(time_step),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample(sample)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int table_sine(input logic [31:0] phase);
        logic [TB_TABLE_BITS-1:0] idx;
        logic [1:0] quad;
        int f;
        int v;
        idx = phase[31 -: TB_TABLE_BITS];
        quad = idx[TB_TABLE_BITS-1 -: 2];
        f = int'(idx[TB_TABLE_BITS-3:0]);
        v = quad[0] ? sine_rom[QTR_LEN - f] : sine_rom[f];
        return quad[1] ? -v : v;
    endfunction

    function automatic logic signed [mtdsb_pkg::SAMPLE_W-1:0] predict_sample(
        input logic [31:0] t);
        logic [31:0] pc;
        logic [31:0] pm;
        longint prod;
        int acc;
        acc = 0;
        for (int n = 0; n < TB_TONES; n++)
        begin
            pc = phase_m[n] + t * cstep_m[n];
            pm = phase_m[n] + t * mstep_m[n];
            prod = longint'(amp_m[n]) * longint'(table_sine(pm + 32'h4000_0000))
                   * longint'(table_sine(pc));
            acc += int'((prod + (longint'(1) <<< 29)) >>> 30);
        end
        return acc[mtdsb_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return {16'($urandom), 16'h8000};
            3: return {16'($urandom), 16'h7FFF};
            4: return 32'($urandom_range(4095));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic apply_setting(input tone_set_t cfg);
        mtdsb_pkg::cfg_field_t fld;
        logic [31:0] word;
        mtdsb_pkg::cfg_field_t field_order [4];
        field_order = '{mtdsb_pkg::FLD_AMP, mtdsb_pkg::FLD_CSTEP, mtdsb_pkg::FLD_MSTEP,
                        mtdsb_pkg::FLD_PHASE};
        for (int tn = 0; tn < mtdsb_pkg::MAX_TONES; tn++)
        begin
            for (int fi = 0; fi < 4; fi++)
            begin
                fld = field_order[fi];
                case (fld)
                    mtdsb_pkg::FLD_AMP: word = cfg[tn].amp_word;
                    mtdsb_pkg::FLD_CSTEP: word = cfg[tn].cstep;
                    mtdsb_pkg::FLD_MSTEP: word = cfg[tn].mstep;
                    default: word = cfg[tn].phase;
                endcase
                @(negedge clk);
                cfg_valid <= 1'b1;
                cfg_index <= {tn[mtdsb_pkg::TONE_SEL_W-1:0], fld};
                cfg_data <= word;
                do
                    @(posedge clk);
                while (!cfg_ready);
                case (fld)
                    mtdsb_pkg::FLD_AMP: amp_m[tn] = word[mtdsb_pkg::AMP_W-1:0];
                    mtdsb_pkg::FLD_CSTEP: cstep_m[tn] = word;
                    mtdsb_pkg::FLD_MSTEP: mstep_m[tn] = word;
                    default: phase_m[tn] = word;
                endcase
            end
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    task automatic wait_drained(input int settle);
        while (steps_q.size() != 0 || in_valid || pending_samples.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic queue_steps(input int count);
        int left;
        int run;
        logic [31:0] t;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(3) == 0)
            begin
                steps_q = {steps_q, $urandom};
                left--;
            end
            else
            begin
                run = $urandom_range(16, 1);
                t = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(2047));
                for (int i = 0; i < run && left > 0; i++)
                begin
                    steps_q = {steps_q, t};
                    t++;
                    left--;
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_acc))
        begin
            if (steps_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                time_step <= steps_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(start_hold);
            recv_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            recv_hold = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        expected_sample_t exp_s;
        in_acc <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("sample %0d with nothing outstanding", sample));
            else
            begin
                exp_s = pending_samples.pop_front();
                samples_checked++;
                if (sample !== exp_s.level)
                    report_mismatch($sformatf("time step %08h: sample %0d, expected %0d",
                                              exp_s.t, sample, exp_s.level));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            exp_s.t = time_step;
            exp_s.level = predict_sample(time_step);
            pending_samples = {pending_samples, exp_s};
            steps_sent++;
        end
    end

    initial
    begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [63:0] x;
        logic [63:0] mag;
        longint acc_s;
        longint v;
        tone_set_t setting;

        for (int k = 0; k <= QTR_LEN; k++)
        begin
            x = (QUARTER_TURN_RAD_Q30 * 64'(k)) / 64'(QTR_LEN);
            mag = x;
            acc_s = longint'(x);
            for (int n = 1; n <= 6; n++)
            begin
                mag = (mag * x) >> 30;
                mag = (mag * x) >> 30;
                mag = mag / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc_s -= longint'(mag);
                else
                    acc_s += longint'(mag);
            end
            if (acc_s < 0)
                acc_s = 0;
            v = (acc_s * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (v > 32767)
                v = 32767;
            sine_rom[k] = int'(v);
        end
        for (int n = 0; n < mtdsb_pkg::MAX_TONES; n++)
        begin
            amp_m[n] = '0;
            cstep_m[n] = '0;
            mstep_m[n] = '0;
            phase_m[n] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        steps_q = '{32'd0, 32'hFFFF_FFFF};
        wait_drained(PIPE_LATENCY);

        setting[0] = '{32'h0000_7FFF, 32'h0040_0000, 32'h0000_0000, 32'h0000_0000};
        setting[1] = '{32'hFFFF_8000, 32'hC000_0000, 32'h0040_0000, 32'h3FFF_FFFF};
        apply_setting(setting);
        steps_q = '{32'd0, 32'd1, 32'd127, 32'd128, 32'd255, 32'd256, 32'd511, 32'd512,
                    32'd767, 32'd768, 32'd1023, 32'hFFFF_FFFF};
        wait_drained(PIPE_LATENCY);

        setting[0] = '{32'h1234_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        setting[1] = '{32'hFFFF_8000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
        apply_setting(setting);
        steps_q = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        wait_drained(PIPE_LATENCY);

        setting[0] = '{32'hABCD_7FFF, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000};
        setting[1] = '{32'h0000_7FFF, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000};
        apply_setting(setting);
        steps_q = '{32'd0, 32'd1, 32'd2, 32'd3};
        wait_drained(PIPE_LATENCY);

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < mtdsb_pkg::MAX_TONES; n++)
                setting[n] = '{pick_word(), pick_word(), pick_word(), pick_word()};
            apply_setting(setting);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 0)
                -> start_hold;
            queue_steps(ITEMS_PER_PHASE / 2);
            if (ph == 1)
                wait_drained(0);
            queue_steps(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            wait_drained(PIPE_LATENCY);
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (PIPE_LATENCY * 4) @(posedge clk);

        $display("Checked %0d samples from %0d time steps over %0d tone settings.",
                 samples_checked, steps_sent, settings_applied);
        $display("Flow control covered free running, sparse input, sparse output and mixed.");
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
